@@ rtl/qtp_pkg.sv @@
`timescale 1ns / 1ps
package qtp_pkg;

    // data word of every item field
    localparam int DW = 32;
    // move duration register width
    localparam int TW = 31;

    // 1.5 s in unsigned q15.16
    localparam logic [TW-1:0] DUR_RESET = 31'd98304;

    localparam logic [DW-1:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [DW-1:0] SAT_MIN = 32'h8000_0000;

endpackage

@@ rtl/qtp_ifs.sv @@
`timescale 1ns / 1ps
interface qtp_item_if;
    logic                           valid;
    logic                           ready;
    logic signed [qtp_pkg::DW-1:0]  sample_time;
    logic signed [qtp_pkg::DW-1:0]  start_pos;
    logic signed [qtp_pkg::DW-1:0]  end_pos;
    modport source (output valid, sample_time, start_pos, end_pos, input ready);
    modport sink (input valid, sample_time, start_pos, end_pos, output ready);
endinterface

interface qtp_point_if;
    logic                           valid;
    logic                           ready;
    logic signed [qtp_pkg::DW-1:0]  ref_position;
    logic signed [qtp_pkg::DW-1:0]  ref_velocity;
    logic signed [qtp_pkg::DW-1:0]  ref_accel;
    modport source (output valid, ref_position, ref_velocity, ref_accel, input ready);
    modport sink (input valid, ref_position, ref_velocity, ref_accel, output ready);
endinterface

interface qtp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [qtp_pkg::TW-1:0]     move_duration;
    modport source (output valid, move_duration, input ready);
    modport sink (input valid, move_duration, output ready);
endinterface

@@ rtl/quintic_trajectory_point.sv @@
// quintic minimum-jerk trajectory point, one axis per transaction
// s, velocity and acceleration come from restoring dividers (31 + 32/59 + 32
// quotient bits, one bit per stage)
// throughput: one transaction per cycle while the output side takes results
// reset (synchronous, active low) clears all valid bits and loads a duration of 1.5 s
`timescale 1ns / 1ps
module quintic_trajectory_point (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qtp_cfg_if.sink       i_cfg,
    qtp_item_if.sink      i_item,
    qtp_point_if.source   o_point
);

    // stage layout
    localparam int D1_LAST    = 30;   // s = t / T, one quotient bit per stage
    localparam int PW_LAST    = 3;    // s^2 .. s^5, one multiplier per stage
    localparam int TL_LAST    = 92;   // rate dividers
    localparam int VEL_STEPS  = 32;   // velocity quotient bits
    localparam int ACC1_STEPS = 59;   // first acceleration quotient bits
    localparam int ACC_CNV    = 60;   // rescale between the two acceleration divisions

    typedef struct packed {
        logic               mid;      // inside the move
        logic               early;    // before start (or zero duration at t = 0)
        logic signed [31:0] p0;
        logic signed [31:0] pt;
        logic signed [32:0] d;
    } t_ctx;

    typedef struct packed {
        logic               v;
        logic signed [31:0] t;
        logic signed [31:0] p0;
        logic signed [31:0] pt;
    } t_in;

    typedef struct packed {
        logic        v;
        t_ctx        c;
        logic [30:0] rem;
        logic [30:0] q;
    } t_d1;

    typedef struct packed {
        logic        v;
        t_ctx        c;
        logic [30:0] s1;
        logic [30:0] s2;
        logic [30:0] s3;
        logic [30:0] s4;
        logic [30:0] s5;
    } t_pw;

    typedef struct packed {
        logic               v;
        t_ctx               c;
        logic signed [39:0] f;
        logic signed [39:0] g;
        logic signed [39:0] h;
    } t_py;

    typedef struct packed {
        logic        v;
        t_ctx        c;
        logic [32:0] dm;
        logic [31:0] fm;
        logic [31:0] gm;
        logic [31:0] hm;
        logic        pneg;
        logic        vneg;
        logic        aneg;
    } t_mg;

    typedef struct packed {
        logic        v;
        t_ctx        c;
        logic        pneg;
        logic        vneg;
        logic        aneg;
        logic [48:0] fh;
        logic [48:0] gh;
        logic [48:0] hh;
        logic [47:0] fl;
        logic [47:0] gl;
        logic [47:0] hl;
    } t_pp;

    typedef struct packed {
        logic        v;
        t_ctx        c;
        logic        pneg;
        logic        vneg;
        logic        aneg;
        logic [63:0] nf;
        logic [63:0] ng;
        logic [63:0] nh;
    } t_sm;

    typedef struct packed {
        logic        v;
        logic        mid;
        logic [31:0] pos;
        logic        vneg;
        logic        vovf;
        logic [30:0] vrem;
        logic [31:0] vw;
        logic        aneg;
        logic        aovf;
        logic [30:0] arem;
        logic [58:0] aw;
    } t_tl;

    typedef struct packed {
        logic        v;
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
    } t_out;

    logic [qtp_pkg::TW-1:0] r_dur;

    t_in  r_in, n_in;
    t_d1  r_d1 [0:D1_LAST];
    t_d1  n_d1 [0:D1_LAST];
    t_pw  r_pw [0:PW_LAST];
    t_pw  n_pw [0:PW_LAST];
    t_py  r_py, n_py;
    t_mg  r_mg, n_mg;
    t_pp  r_pp, n_pp;
    t_sm  r_sm, n_sm;
    t_tl  r_tl [0:TL_LAST];
    t_tl  n_tl [0:TL_LAST];
    t_out r_out, n_out;

    logic en;
    logic in_rdy;

    // one restoring step: shift in b, subtract den when it fits
    // returns {quotient bit, new remainder}
    function automatic logic [31:0] dstep(input logic [30:0] rem, input logic b,
                                          input logic [30:0] den);
        logic [31:0] r;
        logic [31:0] df;
        r  = {rem, b};
        df = r - {1'b0, den};
        if (r >= {1'b0, den}) begin
            dstep = {1'b1, df[30:0]};
        end else begin
            dstep = {1'b0, r[30:0]};
        end
    endfunction

    // q1.30 product, truncated
    function automatic logic [30:0] mulq(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        p    = 62'(a) * 62'(b);
        mulq = p[60:30];
    endfunction

    // saturate a magnitude with a sign to 32 bits
    function automatic logic [31:0] ssat(input logic [31:0] m, input logic neg,
                                         input logic ovf);
        if (ovf) begin
            ssat = neg ? qtp_pkg::SAT_MIN : qtp_pkg::SAT_MAX;
        end else if (!neg) begin
            ssat = m[31] ? qtp_pkg::SAT_MAX : m;
        end else begin
            ssat = (m > qtp_pkg::SAT_MIN) ? qtp_pkg::SAT_MIN : -m;
        end
    endfunction

    // whole pipeline moves when the output register is free or being taken;
    // an empty input stage still takes a transaction while stalled
    assign en     = !r_out.v || o_point.ready;
    assign in_rdy = en || !r_in.v;

    assign i_item.ready = in_rdy;
    assign i_cfg.ready  = 1'b1;

    assign o_point.valid        = r_out.v;
    assign o_point.ref_position = r_out.pos;
    assign o_point.ref_velocity = r_out.vel;
    assign o_point.ref_accel    = r_out.acc;

    // input capture
    always_comb begin
        n_in.v  = i_item.valid;
        n_in.t  = i_item.sample_time;
        n_in.p0 = i_item.start_pos;
        n_in.pt = i_item.end_pos;
    end

    // classify and s = floor(t * 2^30 / T)
    always_comb begin
        logic [30:0] t31;
        logic        ge0;
        logic        bef;
        logic        aft;
        logic [31:0] st;
        t31 = r_in.t[30:0];
        bef = r_in.t[31] || (r_dur == '0 && r_in.t == '0);
        aft = !bef && (t31 > r_dur);
        ge0 = t31 >= r_dur;
        n_d1[0].v        = r_in.v;
        n_d1[0].c.mid    = !bef && !aft;
        n_d1[0].c.early  = bef;
        n_d1[0].c.p0     = r_in.p0;
        n_d1[0].c.pt     = r_in.pt;
        n_d1[0].c.d      = $signed({r_in.pt[31], r_in.pt}) - $signed({r_in.p0[31], r_in.p0});
        n_d1[0].rem      = ge0 ? (t31 - r_dur) : t31;
        n_d1[0].q        = {30'b0, ge0};
        for (int k = 1; k <= D1_LAST; k++) begin
            st           = dstep(r_d1[k-1].rem, 1'b0, r_dur);
            n_d1[k]      = r_d1[k-1];
            n_d1[k].rem  = st[30:0];
            n_d1[k].q    = {r_d1[k-1].q[29:0], st[31]};
        end
    end

    // powers of s
    always_comb begin
        n_pw[0]    = '0;
        n_pw[0].v  = r_d1[D1_LAST].v;
        n_pw[0].c  = r_d1[D1_LAST].c;
        n_pw[0].s1 = r_d1[D1_LAST].q;
        n_pw[0].s2 = mulq(r_d1[D1_LAST].q, r_d1[D1_LAST].q);
        n_pw[1]    = r_pw[0];
        n_pw[1].s3 = mulq(r_pw[0].s2, r_pw[0].s1);
        n_pw[2]    = r_pw[1];
        n_pw[2].s4 = mulq(r_pw[1].s3, r_pw[1].s1);
        n_pw[3]    = r_pw[2];
        n_pw[3].s5 = mulq(r_pw[2].s4, r_pw[2].s1);
    end

    // position, velocity and acceleration shape polynomials
    always_comb begin
        logic signed [39:0] x1, x2, x3, x4, x5;
        x1 = $signed({9'b0, r_pw[PW_LAST].s1});
        x2 = $signed({9'b0, r_pw[PW_LAST].s2});
        x3 = $signed({9'b0, r_pw[PW_LAST].s3});
        x4 = $signed({9'b0, r_pw[PW_LAST].s4});
        x5 = $signed({9'b0, r_pw[PW_LAST].s5});
        n_py.v = r_pw[PW_LAST].v;
        n_py.c = r_pw[PW_LAST].c;
        n_py.f = 10 * x3 - 15 * x4 + 6 * x5;
        n_py.g = 30 * x2 - 60 * x3 + 30 * x4;
        n_py.h = 60 * x1 - 180 * x2 + 120 * x3;
    end

    // magnitudes and signs, acceleration shape rounded to q27
    always_comb begin
        logic [39:0] fa, ga, ha, hr;
        logic        dneg;
        logic [32:0] dn;
        dneg = r_py.c.d[32];
        dn   = -r_py.c.d;
        fa   = r_py.f[39] ? 40'(-r_py.f) : 40'(r_py.f);
        ga   = r_py.g[39] ? 40'(-r_py.g) : 40'(r_py.g);
        ha   = r_py.h[39] ? 40'(-r_py.h) : 40'(r_py.h);
        hr   = ha + 40'd4;
        n_mg.v    = r_py.v;
        n_mg.c    = r_py.c;
        n_mg.dm   = dneg ? dn : r_py.c.d;
        n_mg.fm   = fa[31:0];
        n_mg.gm   = ga[31:0];
        n_mg.hm   = hr[34:3];
        n_mg.pneg = dneg ^ r_py.f[39];
        n_mg.vneg = dneg ^ r_py.g[39];
        n_mg.aneg = dneg ^ r_py.h[39];
    end

    // 33 x 32 products as two partial products each
    always_comb begin
        logic [16:0] dh;
        logic [15:0] dl;
        dh = r_mg.dm[32:16];
        dl = r_mg.dm[15:0];
        n_pp.v    = r_mg.v;
        n_pp.c    = r_mg.c;
        n_pp.pneg = r_mg.pneg;
        n_pp.vneg = r_mg.vneg;
        n_pp.aneg = r_mg.aneg;
        n_pp.fh   = 49'(dh) * 49'(r_mg.fm);
        n_pp.gh   = 49'(dh) * 49'(r_mg.gm);
        n_pp.hh   = 49'(dh) * 49'(r_mg.hm);
        n_pp.fl   = 48'(dl) * 48'(r_mg.fm);
        n_pp.gl   = 48'(dl) * 48'(r_mg.gm);
        n_pp.hl   = 48'(dl) * 48'(r_mg.hm);
    end

    always_comb begin
        n_sm.v    = r_pp.v;
        n_sm.c    = r_pp.c;
        n_sm.pneg = r_pp.pneg;
        n_sm.vneg = r_pp.vneg;
        n_sm.aneg = r_pp.aneg;
        n_sm.nf   = 64'({r_pp.fh, 16'b0}) + 64'(r_pp.fl);
        n_sm.ng   = 64'({r_pp.gh, 16'b0}) + 64'(r_pp.gl);
        n_sm.nh   = 64'({r_pp.hh, 16'b0}) + 64'(r_pp.hl);
    end

    // final position, dividend setup for the rate dividers, then the divider stages
    always_comb begin
        logic [63:0]        pr;
        logic [33:0]        pm;
        logic signed [35:0] term;
        logic signed [36:0] psum;
        logic [31:0]        pclamp;
        logic [63:0]        vx;
        logic [31:0]        st;
        logic [63:0]        y;

        pr   = r_sm.nf + 64'h2000_0000;
        pm   = pr[63:30];
        term = r_sm.pneg ? -$signed({2'b0, pm}) : $signed({2'b0, pm});
        psum = $signed({{5{r_sm.c.p0[31]}}, r_sm.c.p0}) + $signed({term[35], term});
        if (psum[36:31] != {6{psum[36]}}) begin
            pclamp = psum[36] ? qtp_pkg::SAT_MIN : qtp_pkg::SAT_MAX;
        end else begin
            pclamp = psum[31:0];
        end

        // velocity dividend: (n + T * 2^13) / 2^14, then divided by T
        vx = r_sm.ng + {20'b0, r_dur, 13'b0};

        n_tl[0].v    = r_sm.v;
        n_tl[0].mid  = r_sm.c.mid;
        n_tl[0].pos  = r_sm.c.mid ? pclamp : (r_sm.c.early ? r_sm.c.p0 : r_sm.c.pt);
        n_tl[0].vneg = r_sm.vneg;
        n_tl[0].vovf = {13'b0, vx[63:46]} >= r_dur;
        n_tl[0].vrem = {13'b0, vx[63:46]};
        n_tl[0].vw   = vx[45:14];
        // acceleration dividend: 2 * n, 59 quotient bits
        n_tl[0].aneg = r_sm.aneg;
        n_tl[0].aovf = {26'b0, r_sm.nh[62:58]} >= r_dur;
        n_tl[0].arem = {26'b0, r_sm.nh[62:58]};
        n_tl[0].aw   = {r_sm.nh[57:0], 1'b0};

        st = '0;
        y  = '0;
        for (int j = 1; j <= TL_LAST; j++) begin
            n_tl[j] = r_tl[j-1];
            if (j <= VEL_STEPS) begin
                st            = dstep(r_tl[j-1].vrem, r_tl[j-1].vw[31], r_dur);
                n_tl[j].vrem  = st[30:0];
                n_tl[j].vw    = {r_tl[j-1].vw[30:0], st[31]};
            end
            if (j <= ACC1_STEPS) begin
                st            = dstep(r_tl[j-1].arem, r_tl[j-1].aw[58], r_dur);
                n_tl[j].arem  = st[30:0];
                n_tl[j].aw    = {r_tl[j-1].aw[57:0], st[31]};
            end else if (j == ACC_CNV) begin
                // second division: (16 q + T/2) / T
                y             = 64'({r_tl[j-1].aw, 4'b0}) + {34'b0, r_dur[30:1]};
                n_tl[j].aovf  = r_tl[j-1].aovf || (y[63:32] >= {1'b0, r_dur});
                n_tl[j].arem  = y[62:32];
                n_tl[j].aw    = {27'b0, y[31:0]};
            end else begin
                st            = dstep(r_tl[j-1].arem, r_tl[j-1].aw[31], r_dur);
                n_tl[j].arem  = st[30:0];
                n_tl[j].aw    = {27'b0, r_tl[j-1].aw[30:0], st[31]};
            end
        end
    end

    // output register, rates forced to zero outside the move
    always_comb begin
        t_tl l;
        l = r_tl[TL_LAST];
        n_out.v   = l.v;
        n_out.pos = l.pos;
        n_out.vel = l.mid ? ssat(l.vw, l.vneg && (l.vovf || l.vw != '0), l.vovf) : '0;
        n_out.acc = l.mid ? ssat(l.aw[31:0], l.aneg && (l.aovf || l.aw[31:0] != '0),
                                 l.aovf) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur   <= qtp_pkg::DUR_RESET;
            r_in.v  <= 1'b0;
            for (int k = 0; k <= D1_LAST; k++) begin
                r_d1[k].v <= 1'b0;
            end
            for (int k = 0; k <= PW_LAST; k++) begin
                r_pw[k].v <= 1'b0;
            end
            r_py.v  <= 1'b0;
            r_mg.v  <= 1'b0;
            r_pp.v  <= 1'b0;
            r_sm.v  <= 1'b0;
            for (int k = 0; k <= TL_LAST; k++) begin
                r_tl[k].v <= 1'b0;
            end
            r_out.v <= 1'b0;
        end else begin
            // config transaction
            if (i_cfg.valid) begin
                r_dur <= i_cfg.move_duration;
            end
            if (in_rdy) begin
                r_in <= n_in;
            end
            if (en) begin
                r_d1  <= n_d1;
                r_pw  <= n_pw;
                r_py  <= n_py;
                r_mg  <= n_mg;
                r_pp  <= n_pp;
                r_sm  <= n_sm;
                r_tl  <= n_tl;
                r_out <= n_out;
            end
        end
    end

endmodule

@@ rtl/qtp_checker.sv @@
`timescale 1ns / 1ps
module qtp_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [qtp_pkg::DW-1:0]   i_pos,
    input logic [qtp_pkg::DW-1:0]   i_vel,
    input logic [qtp_pkg::DW-1:0]   i_acc
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // input side never blocks while the output can move
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_ready || !i_out_valid) |-> i_in_ready)
        else $error("input stalled with free output");

    // a waiting result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_pos) && $stable(i_vel) && $stable(i_acc)))
        else $error("stalled result changed");

endmodule

bind quintic_trajectory_point qtp_checker u_qtp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_point.valid),
    .i_out_ready (o_point.ready),
    .i_pos       (o_point.ref_position),
    .i_vel       (o_point.ref_velocity),
    .i_acc       (o_point.ref_accel)
);
